FILE: rtl/bgr_pkg.sv
package bgr_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int CFG_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int GESTURE_WIDTH = 3;
  localparam int STATE_WIDTH = 3;
  localparam int TAP_WIDTH = 2;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MULTI_TAP = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG      = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET  = 16'd25;
  localparam logic [CFG_WIDTH-1:0] MULTI_TAP_RESET = 16'd250;
  localparam logic [CFG_WIDTH-1:0] LONG_RESET      = 16'd800;

  // gesture machine states
  localparam logic [STATE_WIDTH-1:0] ST_IDLE       = 3'd0;
  localparam logic [STATE_WIDTH-1:0] ST_DOWN_FIRST = 3'd1;
  localparam logic [STATE_WIDTH-1:0] ST_BETWEEN    = 3'd2;
  localparam logic [STATE_WIDTH-1:0] ST_DOWN_MORE  = 3'd3;
  localparam logic [STATE_WIDTH-1:0] ST_LONG_FIRED = 3'd4;

  // gesture codes
  localparam logic [GESTURE_WIDTH-1:0] G_NONE       = 3'd0;
  localparam logic [GESTURE_WIDTH-1:0] G_SINGLE     = 3'd1;
  localparam logic [GESTURE_WIDTH-1:0] G_DOUBLE     = 3'd2;
  localparam logic [GESTURE_WIDTH-1:0] G_TRIPLE     = 3'd3;
  localparam logic [GESTURE_WIDTH-1:0] G_LONG       = 3'd4;
  localparam logic [GESTURE_WIDTH-1:0] G_CLICK_HOLD = 3'd5;

  localparam logic [TAP_WIDTH-1:0] TAPS_MAX = 2'd3;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] multi_tap_ticks;
    logic [CFG_WIDTH-1:0] long_ticks;
  } fsm_cfg_t;

  typedef struct packed {
    logic [GESTURE_WIDTH-1:0] gesture;
    logic                     idle;
  } fsm_result_t;

endpackage

FILE: rtl/bgr_edge_filter.sv
module bgr_edge_filter import bgr_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  level,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [CFG_WIDTH-1:0]  debounce_ticks,
  output logic                  edge_hit
);

  logic                  prev_raw_level;
  logic                  accepted_level;
  logic [TIME_WIDTH-1:0] last_edge_time;
  logic [TIME_WIDTH-1:0] since_edge;

  assign since_edge = now - last_edge_time;
  assign edge_hit = (level != prev_raw_level) && (level != accepted_level) &&
                    (since_edge >= {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, debounce_ticks});

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw_level <= 1'b1;
      accepted_level <= 1'b1;
      last_edge_time <= '0;
    end else if (step) begin
      prev_raw_level <= level;
      if (edge_hit) begin
        accepted_level <= level;
        last_edge_time <= now;
      end
    end
  end

endmodule

FILE: rtl/bgr_gesture_fsm.sv
module bgr_gesture_fsm import bgr_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  edge_hit,
  input  logic                  down,
  input  logic [TIME_WIDTH-1:0] now,
  input  fsm_cfg_t              cfg,
  output fsm_result_t           result
);

  logic [STATE_WIDTH-1:0] state;
  logic [STATE_WIDTH-1:0] state_next;
  logic [TIME_WIDTH-1:0]  phase_start;
  logic [TIME_WIDTH-1:0]  phase_start_next;
  logic [TAP_WIDTH-1:0]   taps;
  logic [TAP_WIDTH-1:0]   taps_next;

  logic [STATE_WIDTH-1:0] st;
  logic [STATE_WIDTH-1:0] st1;
  logic [TAP_WIDTH-1:0]   taps1;
  logic                   phase_moved;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   hold_old;
  logic                   tap_old;
  logic                   hold_now;
  logic                   tap_now;
  logic [GESTURE_WIDTH-1:0] gesture;

  assign elapsed  = now - phase_start;
  assign hold_old = elapsed >= {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, cfg.long_ticks};
  assign tap_old  = elapsed >= {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, cfg.multi_tap_ticks};
  // a phase that restarts this tick has zero elapsed time
  assign hold_now = phase_moved ? (cfg.long_ticks == '0) : hold_old;
  assign tap_now  = phase_moved ? (cfg.multi_tap_ticks == '0) : tap_old;

  always_comb begin
    st = (state > ST_LONG_FIRED) ? ST_IDLE : state;
    st1 = st;
    taps1 = taps;
    phase_moved = 1'b0;
    phase_start_next = phase_start;
    state_next = st;
    taps_next = taps;
    gesture = G_NONE;

    if (edge_hit) begin
      case (st)
        ST_IDLE: begin
          if (down) begin
            st1 = ST_DOWN_FIRST;
            phase_moved = 1'b1;
            taps1 = '0;
          end
        end
        ST_DOWN_FIRST, ST_DOWN_MORE: begin
          if (!down) begin
            if (taps1 != TAPS_MAX) taps1 = taps1 + 1'b1;
            st1 = ST_BETWEEN;
            phase_moved = 1'b1;
          end
        end
        ST_BETWEEN: begin
          if (down) begin
            st1 = ST_DOWN_MORE;
            phase_moved = 1'b1;
          end
        end
        default: begin
          if (!down) begin
            st1 = ST_IDLE;
            taps1 = '0;
          end
        end
      endcase
    end
    if (phase_moved) phase_start_next = now;

    if (edge_hit && !down && hold_old && st == ST_DOWN_FIRST) begin
      // release after a full hold
      state_next = ST_IDLE;
      taps_next = '0;
      phase_start_next = phase_start;
      gesture = G_LONG;
    end else if (edge_hit && !down && hold_old && st == ST_DOWN_MORE) begin
      state_next = ST_IDLE;
      taps_next = '0;
      phase_start_next = phase_start;
      gesture = G_CLICK_HOLD;
    end else if (st1 == ST_DOWN_FIRST && hold_now) begin
      state_next = ST_LONG_FIRED;
      taps_next = '0;
      gesture = G_LONG;
    end else if (st1 == ST_DOWN_MORE && hold_now) begin
      state_next = ST_LONG_FIRED;
      taps_next = '0;
      gesture = G_CLICK_HOLD;
    end else if (st1 == ST_BETWEEN && tap_now) begin
      state_next = ST_IDLE;
      taps_next = '0;
      if (taps1 == 2'd1)      gesture = G_SINGLE;
      else if (taps1 == 2'd2) gesture = G_DOUBLE;
      else                    gesture = G_TRIPLE;
    end else begin
      state_next = st1;
      taps_next = taps1;
    end
  end

  assign result.gesture = gesture;
  assign result.idle = (state_next == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase_start <= '0;
      taps <= '0;
    end else if (step) begin
      state <= state_next;
      phase_start <= phase_start_next;
      taps <= taps_next;
    end
  end

endmodule

FILE: rtl/button_gesture_recognizer.sv
// button gesture recognizer: every input beat is one millisecond tick carrying the raw
// active-low pin level (0 pressed, 1 released), and every input beat yields exactly one
// result beat with a gesture code (0 none, 1 single, 2 double, 3 triple, 4 long press,
// 5 click-and-hold) and an idle flag that says the machine may sleep. edges are accepted
// only when the raw level toggles, differs from the last accepted level and at least
// debounce_ticks have passed since the last accepted edge. one beat per clock is
// sustained while out_ready stays high: a tick waits in the input register, is resolved
// by the edge filter and gesture machine in a single pass, and lands in the result
// register. the time stamp advances once per processed tick and wraps at TIME_WIDTH
// bits. configuration: cfg_index 0 debounce_ticks, 1 multi_tap_ticks, 2 long_ticks;
// write only while idle.
module button_gesture_recognizer import bgr_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       pin_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [GESTURE_WIDTH-1:0]   gesture,
  output logic                       idle_flag,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data
);

  // configuration registers
  logic [CFG_WIDTH-1:0] debounce_ticks;
  fsm_cfg_t             cfg;

  // input register and tick time stamp
  logic                  hold_valid;
  logic                  hold_level;
  logic [TIME_WIDTH-1:0] tick_count;

  logic        advance;
  logic        edge_hit;
  fsm_result_t result;

  // the held tick moves on when the result register is free or being drained
  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      cfg.multi_tap_ticks <= MULTI_TAP_RESET;
      cfg.long_ticks <= LONG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:  debounce_ticks <= cfg_data;
        REG_MULTI_TAP: cfg.multi_tap_ticks <= cfg_data;
        REG_LONG:      cfg.long_ticks <= cfg_data;
        default:       ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_level <= pin_level;
    end
  end

  // tick time stamp, one step per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (advance) begin
      tick_count <= tick_count + 1'b1;
    end
  end

  bgr_edge_filter #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_edge_filter (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .level         (hold_level),
    .now           (tick_count),
    .debounce_ticks(debounce_ticks),
    .edge_hit      (edge_hit)
  );

  bgr_gesture_fsm #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_gesture_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .edge_hit(edge_hit),
    .down    (!hold_level),
    .now     (tick_count),
    .cfg     (cfg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture <= result.gesture;
      idle_flag <= result.idle;
    end
  end

`ifndef SYNTH
  // tap gestures always return the machine to idle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (gesture == G_SINGLE || gesture == G_DOUBLE || gesture == G_TRIPLE)
    |-> idle_flag)
    else $error("tap gesture reported without idle");

  // only defined gesture codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gesture <= G_CLICK_HOLD)
    else $error("gesture code out of range");

  // a held tick that cannot move stays in the input register
  assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_level))
    else $error("held tick lost");

  // the time stamp moves exactly with processed ticks
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(tick_count))
    else $error("time stamp moved without a tick");
`endif

endmodule
